// File: design/gfta_pkg.sv
// shared constants and types for the gtp-u flow tunnel assigner
package gfta_pkg;

  localparam int unsigned TableEntries = 16;

  localparam logic [15:0] EthLen        = 16'd14;
  localparam logic [15:0] MinFrame      = 16'd42;
  localparam logic [15:0] TypeIpv4      = 16'h0800;
  localparam logic [7:0]  ProtoUdp      = 8'd17;
  localparam logic [15:0] OuterIpExtra  = 16'd36;
  localparam logic [15:0] OuterUdpExtra = 16'd16;

  localparam logic [15:0] MatchPortRst = 16'd453;
  localparam logic [15:0] TeidLimitRst = 16'd65535;
  localparam logic [31:0] PeerIpRst    = 32'hC0A80164;
  localparam logic [31:0] LocalIpRst   = 32'h0A0A0A0A;
  localparam logic [15:0] TunnelFirst  = 16'd1;

  localparam int unsigned CfgIdxW = 2;
  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  localparam cfg_idx_t RegMatchPort = 2'd0;
  localparam cfg_idx_t RegTeidLimit = 2'd1;
  localparam cfg_idx_t RegPeerIp    = 2'd2;
  localparam cfg_idx_t RegLocalIp   = 2'd3;

endpackage

// File: design/gfta_if.sv
// handshake channel interfaces: header summary in, descriptor out, register writes
interface gfta_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] frame_length;
  logic [15:0] ethertype;
  logic [7:0]  ip_protocol;
  logic [15:0] udp_dst_port;
  logic [31:0] src_ip;
  modport source (output valid, frame_length, ethertype, ip_protocol, udp_dst_port,
                  src_ip, input ready);
  modport sink (input valid, frame_length, ethertype, ip_protocol, udp_dst_port,
                src_ip, output ready);
endinterface

interface gfta_out_if;
  logic        valid;
  logic        ready;
  logic        encapsulated;
  logic        flow_alloc;
  logic [15:0] tunnel_id;
  logic [15:0] outer_total_length;
  logic [15:0] outer_udp_length;
  logic [15:0] gtp_length;
  logic [31:0] outer_dst_ip;
  logic [31:0] outer_src_ip;
  modport source (output valid, encapsulated, flow_alloc, tunnel_id, outer_total_length,
                  outer_udp_length, gtp_length, outer_dst_ip, outer_src_ip, input ready);
  modport sink (input valid, encapsulated, flow_alloc, tunnel_id, outer_total_length,
                outer_udp_length, gtp_length, outer_dst_ip, outer_src_ip, output ready);
endinterface

interface gfta_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [gfta_pkg::CfgIdxW-1:0] index;
  logic [31:0]               data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: design/gtpu_flow_tunnel_assigner.sv
// top level: frame match, lru flow table and tunnel descriptor
// One frame at a time. An unmatched frame goes from acceptance straight to the output
// state, where its word is loaded into the output register, and the block then returns
// to idle to accept the next frame. A matched frame is walked through the flow table ram
// twice, one entry per cycle: a lookup pass (hit, lowest free entry, oldest entry) and
// an age update pass that writes back the new recency ranks. Its word is loaded in the
// output state that follows the age update pass. The single read port of the table ram
// is why the table is walked one entry at a time. A word waiting on the output holds
// only the last step of the next frame.
// Valid bits live in flip-flops and clear at reset; no clearing pass is needed.
module gtpu_flow_tunnel_assigner #(
  parameter int unsigned TABLE_ENTRIES = gfta_pkg::TableEntries
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  gfta_in_if.sink     in_i,
  gfta_out_if.source  out_o,
  gfta_cfg_if.sink    cfg_i
);

  localparam int unsigned AW   = $clog2(TABLE_ENTRIES);
  localparam int unsigned CW   = AW + 1;
  localparam int unsigned OW   = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned EW   = 32 + 16 + AW;
  localparam logic [CW-1:0] CntEnd  = CW'(TABLE_ENTRIES);
  localparam logic [AW-1:0] LastIdx = AW'(TABLE_ENTRIES - 1);
  localparam logic [OW-1:0] AgeFree = OW'(TABLE_ENTRIES);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_UPDATE = 2'd2;
  localparam logic [1:0] S_OUT    = 2'd3;

  logic [1:0]  state_q, state_d;
  logic [15:0] match_port_q, teid_limit_q;
  logic [31:0] peer_ip_q, local_ip_q;
  logic [15:0] next_q;
  logic [TABLE_ENTRIES-1:0] valid_q;

  logic [15:0] flen_q;
  logic [31:0] key_q;
  logic        match_q;

  logic [CW-1:0] cnt_q;
  logic          pend_q;
  logic [AW-1:0] pidx_q;

  logic          hit_q, free_q;
  logic [AW-1:0] hslot_q, fslot_q, lslot_q;
  logic [AW-1:0] hage_q, lage_q;
  logic [15:0]   htun_q;
  logic [15:0]   tid_q;

  logic        ovalid_q, oencap_q, onew_q;
  logic [15:0] otid_q, otot_q, oudp_q, ogtp_q;
  logic [31:0] odst_q, osrc_q;

  logic          in_acc, out_load, last_rd;
  logic          re, we;
  logic [AW-1:0] raddr;
  logic [EW-1:0] rdata, wdata;
  logic [31:0]   rkey;
  logic [15:0]   rtun;
  logic [AW-1:0] rage;
  logic [AW-1:0] slot_w;
  logic [OW-1:0] oage_w;
  logic [15:0]   tid_w;
  logic [16:0]   next_inc;
  logic [15:0]   ip_len;
  logic          in_match;

  assign in_acc   = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign out_load = (state_q == S_OUT) && (!ovalid_q || out_o.ready);
  assign last_rd  = pend_q && (pidx_q == LastIdx);

  assign in_match = (in_i.frame_length >= gfta_pkg::MinFrame) &&
                    (in_i.ethertype == gfta_pkg::TypeIpv4) &&
                    (in_i.ip_protocol == gfta_pkg::ProtoUdp) &&
                    (in_i.udp_dst_port == match_port_q);

  assign re    = ((state_q == S_SCAN) || (state_q == S_UPDATE)) && (cnt_q < CntEnd);
  assign raddr = cnt_q[AW-1:0];
  assign rkey  = rdata[EW-1 -: 32];
  assign rtun  = rdata[AW +: 16];
  assign rage  = rdata[AW-1:0];

  // chosen entry and the age it leaves behind
  always_comb begin
    if (hit_q) begin
      slot_w = hslot_q;
      oage_w = OW'(hage_q);
      tid_w  = htun_q;
    end else if (free_q) begin
      slot_w = fslot_q;
      oage_w = AgeFree;
      tid_w  = next_q;
    end else begin
      slot_w = lslot_q;
      oage_w = OW'(lage_q);
      tid_w  = next_q;
    end
  end

  // age update pass: target goes to rank zero, younger valid entries age by one
  always_comb begin
    we    = 1'b0;
    wdata = {rkey, rtun, rage + AW'(1)};
    if ((state_q == S_UPDATE) && pend_q) begin
      if (pidx_q == slot_w) begin
        we    = 1'b1;
        wdata = {key_q, tid_w, {AW{1'b0}}};
      end else if (valid_q[pidx_q] && (OW'(rage) < oage_w)) begin
        we = 1'b1;
      end
    end
  end

  gfta_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (pidx_q),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_acc) state_d = in_match ? S_SCAN : S_OUT;
      S_SCAN:   if (last_rd) state_d = S_UPDATE;
      S_UPDATE: if (last_rd) state_d = S_OUT;
      S_OUT:    if (out_load) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  assign next_inc = {1'b0, next_q} + 17'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      match_port_q <= gfta_pkg::MatchPortRst;
      teid_limit_q <= gfta_pkg::TeidLimitRst;
      peer_ip_q    <= gfta_pkg::PeerIpRst;
      local_ip_q   <= gfta_pkg::LocalIpRst;
      next_q       <= gfta_pkg::TunnelFirst;
      valid_q      <= '0;
      cnt_q        <= '0;
      pend_q       <= 1'b0;
      hit_q        <= 1'b0;
      free_q       <= 1'b0;
      ovalid_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= re;
      if (cfg_i.valid) begin
        unique case (cfg_i.index)
          gfta_pkg::RegMatchPort: match_port_q <= cfg_i.data[15:0];
          gfta_pkg::RegTeidLimit: teid_limit_q <= cfg_i.data[15:0];
          gfta_pkg::RegPeerIp:    peer_ip_q    <= cfg_i.data;
          gfta_pkg::RegLocalIp:   local_ip_q   <= cfg_i.data;
          default: ;
        endcase
      end
      if (in_acc) begin
        cnt_q  <= '0;
        hit_q  <= 1'b0;
        free_q <= 1'b0;
      end else if (re) begin
        cnt_q <= cnt_q + CW'(1);
      end
      if ((state_q == S_SCAN) && last_rd) begin
        cnt_q <= '0;
      end
      if ((state_q == S_SCAN) && pend_q) begin
        if (valid_q[pidx_q] && (rkey == key_q) && !hit_q) begin
          hit_q <= 1'b1;
        end
        if (!valid_q[pidx_q] && !free_q) begin
          free_q <= 1'b1;
        end
      end
      if ((state_q == S_UPDATE) && last_rd) begin
        valid_q[slot_w] <= 1'b1;
        if (!hit_q) begin
          next_q <= (next_inc > {1'b0, teid_limit_q}) ? gfta_pkg::TunnelFirst
                                                     : next_inc[15:0];
        end
      end
      if (out_load) begin
        ovalid_q <= 1'b1;
      end else if (out_o.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pidx_q <= raddr;
    if (in_acc) begin
      flen_q  <= in_i.frame_length;
      key_q   <= in_i.src_ip;
      match_q <= in_match;
      lslot_q <= '0;
      lage_q  <= '0;
    end
    if ((state_q == S_SCAN) && pend_q) begin
      if (valid_q[pidx_q] && (rkey == key_q) && !hit_q) begin
        hslot_q <= pidx_q;
        hage_q  <= rage;
        htun_q  <= rtun;
      end
      if (!valid_q[pidx_q] && !free_q) begin
        fslot_q <= pidx_q;
      end
      if (valid_q[pidx_q] && (rage > lage_q)) begin
        lslot_q <= pidx_q;
        lage_q  <= rage;
      end
    end
    if ((state_q == S_UPDATE) && last_rd) begin
      tid_q <= tid_w;
    end
    if (out_load) begin
      oencap_q <= match_q;
      onew_q   <= match_q && !hit_q;
      otid_q   <= match_q ? tid_q : 16'd0;
      otot_q   <= match_q ? ip_len + gfta_pkg::OuterIpExtra : 16'd0;
      oudp_q   <= match_q ? ip_len + gfta_pkg::OuterUdpExtra : 16'd0;
      ogtp_q   <= match_q ? ip_len : 16'd0;
      odst_q   <= match_q ? peer_ip_q : 32'd0;
      osrc_q   <= match_q ? local_ip_q : 32'd0;
    end
  end

  assign ip_len = flen_q - gfta_pkg::EthLen;

  assign out_o.valid              = ovalid_q;
  assign out_o.encapsulated       = oencap_q;
  assign out_o.flow_alloc         = onew_q;
  assign out_o.tunnel_id          = otid_q;
  assign out_o.outer_total_length = otot_q;
  assign out_o.outer_udp_length   = oudp_q;
  assign out_o.gtp_length         = ogtp_q;
  assign out_o.outer_dst_ip       = odst_q;
  assign out_o.outer_src_ip       = osrc_q;

  a_next_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_q != 16'd0) else $error("tunnel id counter reached zero");

  a_new_is_encap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && onew_q |-> oencap_q) else $error("new flow word not encapsulated");

  a_encap_tid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && oencap_q |-> otid_q != 16'd0) else $error("encapsulated with tunnel id 0");

  a_valid_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##1 $countones(valid_q) >= $countones($past(valid_q)))
    else $error("flow table entry lost its valid bit");

endmodule

// File: design/gfta_ram.sv
// generic simple dual-port ram with registered read
module gfta_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// File: test/tb_gtpu_flow_tunnel_assigner.sv
// testbench for the gtp-u flow tunnel assigner: directed table, random frames, lru predictor
module tb_gtpu_flow_tunnel_assigner;

  typedef struct packed {
    logic [15:0] flen;
    logic [15:0] etype;
    logic [7:0]  proto;
    logic [15:0] dport;
    logic [31:0] sip;
  } hdr_t;

  typedef struct packed {
    logic        encap;
    logic        fresh;
    logic [15:0] tid;
    logic [15:0] tot_len;
    logic [15:0] udp_len;
    logic [15:0] gtp_len;
    logic [31:0] dst;
    logic [31:0] src;
  } desc_t;

  typedef struct {
    hdr_t  h;
    bit    has_exp;
    desc_t d;
  } row_t;

  localparam int NumRandom = 600;
  localparam int WatchLimit = 20000;
  localparam int HoldCycles = 300;

  logic clk_i, rst_ni;
  gfta_in_if  in_if ();
  gfta_out_if out_if ();
  gfta_cfg_if cfg_if ();

  gtpu_flow_tunnel_assigner dut (
    .clk_i (clk_i), .rst_ni(rst_ni), .in_i(in_if.sink), .out_o(out_if.source),
    .cfg_i (cfg_if.sink)
  );

  // predictor state
  logic [15:0] p_match_port, p_teid_limit, p_next_tid;
  logic [31:0] p_peer, p_local;
  logic [31:0] tab_key [gfta_pkg::TableEntries];
  logic [15:0] tab_tid [gfta_pkg::TableEntries];
  bit          tab_vld [gfta_pkg::TableEntries];
  int          tab_age [gfta_pkg::TableEntries];

  desc_t expected_desc_q[$];
  int    errors = 0;
  int    words_seen = 0;
  int    encap_seen = 0;
  int    evict_seen = 0;
  int    idle_cnt = 0;
  int    hold_cnt = 0;
  bit    no_idle = 0;
  bit    hold_go = 0;

  initial begin
    clk_i = 0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic void lru_touch(int idx, int old_age);
    for (int i = 0; i < gfta_pkg::TableEntries; i++) begin
      if (i != idx && tab_vld[i] && tab_age[i] < old_age) tab_age[i]++;
    end
    tab_age[idx] = 0;
  endfunction

  function automatic desc_t assign_tunnel(hdr_t h);
    desc_t d;
    int slot;
    int old_age;
    bit hit;
    bit free_found;
    d = '0;
    hit = 0;
    free_found = 0;
    slot = 0;
    if (h.flen < gfta_pkg::MinFrame || h.etype != gfta_pkg::TypeIpv4 ||
        h.proto != gfta_pkg::ProtoUdp || h.dport != p_match_port) return d;
    for (int i = 0; i < gfta_pkg::TableEntries; i++) begin
      if (!hit && tab_vld[i] && tab_key[i] == h.sip) begin
        hit = 1;
        slot = i;
      end
    end
    if (hit) begin
      d.tid = tab_tid[slot];
      lru_touch(slot, tab_age[slot]);
    end else begin
      for (int i = 0; i < gfta_pkg::TableEntries; i++) begin
        if (!free_found && !tab_vld[i]) begin
          free_found = 1;
          slot = i;
        end
      end
      if (free_found) old_age = gfta_pkg::TableEntries;
      else begin
        slot = 0;
        for (int i = 1; i < gfta_pkg::TableEntries; i++)
          if (tab_age[i] > tab_age[slot]) slot = i;
        old_age = tab_age[slot];
        evict_seen++;
      end
      d.tid = p_next_tid;
      if (17'(p_next_tid) + 1 > 17'(p_teid_limit)) p_next_tid = gfta_pkg::TunnelFirst;
      else p_next_tid = p_next_tid + 16'd1;
      tab_key[slot] = h.sip;
      tab_tid[slot] = d.tid;
      tab_vld[slot] = 1;
      lru_touch(slot, old_age);
      d.fresh = 1;
    end
    d.encap = 1;
    d.gtp_len = h.flen - gfta_pkg::EthLen;
    d.tot_len = d.gtp_len + gfta_pkg::OuterIpExtra;
    d.udp_len = d.gtp_len + gfta_pkg::OuterUdpExtra;
    d.dst = p_peer;
    d.src = p_local;
    return d;
  endfunction

  // valid stays high between back to back writes; the caller drops it after the group
  task automatic write_reg(gfta_pkg::cfg_idx_t idx, logic [31:0] val);
    cfg_if.valid <= 1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    unique case (idx)
      gfta_pkg::RegMatchPort: p_match_port = val[15:0];
      gfta_pkg::RegTeidLimit: p_teid_limit = val[15:0];
      gfta_pkg::RegPeerIp:    p_peer = val;
      gfta_pkg::RegLocalIp:   p_local = val;
      default: ;
    endcase
  endtask

  // drive one header word; valid stays high unless an idle gap follows
  task automatic send_frame(hdr_t h, bit has_fixed, desc_t fixed);
    desc_t d;
    in_if.valid <= 1;
    {in_if.frame_length, in_if.ethertype, in_if.ip_protocol, in_if.udp_dst_port,
     in_if.src_ip} <= h;
    do @(posedge clk_i); while (!in_if.ready);
    d = assign_tunnel(h);
    expected_desc_q.push_back(has_fixed ? fixed : d);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    while (expected_desc_q.size() != 0 && guard < WatchLimit) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (2 * gfta_pkg::TableEntries + 10) @(posedge clk_i);
  endtask

  function automatic hdr_t good_frame(logic [31:0] sip);
    hdr_t h;
    h.flen = $urandom_range(0, 7) == 0 ? 16'($urandom_range(42, 65535))
                                       : 16'($urandom_range(42, 1514));
    h.etype = gfta_pkg::TypeIpv4;
    h.proto = gfta_pkg::ProtoUdp;
    h.dport = p_match_port;
    h.sip = sip;
    return h;
  endfunction

  function automatic hdr_t noise_frame();
    hdr_t h;
    h = good_frame($urandom);
    case ($urandom_range(0, 4))
      0: h.flen = 16'($urandom_range(0, 41));
      1: h.etype = 16'($urandom);
      2: h.proto = 8'($urandom);
      3: h.dport = 16'($urandom);
      default: h = hdr_t'(88'({$urandom, $urandom, $urandom}));
    endcase
    return h;
  endfunction

  // output side: random stalls, one long hold-off counted here
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 0;
      idle_cnt <= 0;
      hold_cnt <= 0;
    end else if (hold_go && hold_cnt < HoldCycles) begin
      hold_cnt <= hold_cnt + 1;
      out_if.ready <= 0;
    end else if (idle_cnt > 0) begin
      idle_cnt <= idle_cnt - 1;
      out_if.ready <= 0;
    end else if (!no_idle && $urandom_range(0, 7) == 0) begin
      idle_cnt <= $urandom_range(0, 14);
      out_if.ready <= 0;
    end else begin
      out_if.ready <= 1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      desc_t got, want;
      got = {out_if.encapsulated, out_if.flow_alloc, out_if.tunnel_id,
             out_if.outer_total_length, out_if.outer_udp_length, out_if.gtp_length,
             out_if.outer_dst_ip, out_if.outer_src_ip};
      words_seen++;
      if (got.encap) encap_seen++;
      if (expected_desc_q.size() == 0) begin
        $display("%0t unexpected word: actual %h", $time, got);
        errors++;
      end else begin
        want = expected_desc_q.pop_front();
        if (got.encap !== want.encap || got.fresh !== want.fresh ||
            got.tid !== want.tid || got.tot_len !== want.tot_len ||
            got.udp_len !== want.udp_len || got.gtp_len !== want.gtp_len ||
            got.dst !== want.dst || got.src !== want.src) begin
          $display("%0t mismatch: expected %h actual %h", $time, want, got);
          errors++;
        end
      end
    end
  end

  // watchdog on accepted traffic
  int quiet = 0;
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WatchLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    row_t  rows[$];
    desc_t z;
    logic [31:0] pool[$];
    int    k;
    rst_ni = 0;
    in_if.valid = 0;
    in_if.frame_length = 0;
    in_if.ethertype = 0;
    in_if.ip_protocol = 0;
    in_if.udp_dst_port = 0;
    in_if.src_ip = 0;
    cfg_if.valid = 0;
    cfg_if.index = gfta_pkg::RegMatchPort;
    cfg_if.data = 0;
    p_match_port = gfta_pkg::MatchPortRst;
    p_teid_limit = gfta_pkg::TeidLimitRst;
    p_peer = gfta_pkg::PeerIpRst;
    p_local = gfta_pkg::LocalIpRst;
    p_next_tid = gfta_pkg::TunnelFirst;
    for (int i = 0; i < gfta_pkg::TableEntries; i++) begin
      tab_vld[i] = 0; tab_age[i] = 0; tab_key[i] = 0; tab_tid[i] = 0;
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed rows at reset settings
    z = '0;
    rows.push_back('{'{16'd41, gfta_pkg::TypeIpv4, gfta_pkg::ProtoUdp, 16'd453, 32'h1},
                     1'b1, z});
    rows.push_back('{'{16'd42, 16'h0801, gfta_pkg::ProtoUdp, 16'd453, 32'h1}, 1'b1, z});
    rows.push_back('{'{16'd100, gfta_pkg::TypeIpv4, 8'd6, 16'd453, 32'h1}, 1'b1, z});
    rows.push_back('{'{16'd100, gfta_pkg::TypeIpv4, gfta_pkg::ProtoUdp, 16'd2152, 32'h1},
                     1'b1, z});
    rows.push_back('{'{16'hffff, 16'hffff, 8'hff, 16'hffff, 32'hffffffff}, 1'b1, z});
    rows.push_back('{'{16'd0, 16'd0, 8'd0, 16'd0, 32'd0}, 1'b1, z});
    rows.push_back('{'{16'd42, gfta_pkg::TypeIpv4, gfta_pkg::ProtoUdp, 16'd453, 32'h0},
                     1'b1, '{1'b1, 1'b1, 16'd1, 16'd64, 16'd44, 16'd28,
                             gfta_pkg::PeerIpRst, gfta_pkg::LocalIpRst}});
    rows.push_back('{'{16'd42, gfta_pkg::TypeIpv4, gfta_pkg::ProtoUdp, 16'd453, 32'h0},
                     1'b1, '{1'b1, 1'b0, 16'd1, 16'd64, 16'd44, 16'd28,
                             gfta_pkg::PeerIpRst, gfta_pkg::LocalIpRst}});
    rows.push_back('{'{16'hffff, gfta_pkg::TypeIpv4, gfta_pkg::ProtoUdp, 16'd453,
                       32'hffffffff},
                     1'b1, '{1'b1, 1'b1, 16'd2, 16'd21, 16'd1, 16'hfff1,
                             gfta_pkg::PeerIpRst, gfta_pkg::LocalIpRst}});
    for (int i = 0; i < 16; i++)
      rows.push_back('{'{16'(60 + i), gfta_pkg::TypeIpv4, gfta_pkg::ProtoUdp, 16'd453,
                         32'(32'h100 + i)}, 1'b0, z});
    foreach (rows[i]) send_frame(rows[i].h, rows[i].has_exp, rows[i].d);
    in_if.valid <= 0;
    drain();

    // extreme settings: port 0, limit 1 (every id 1), zero peer, all-ones local
    write_reg(gfta_pkg::RegMatchPort, 32'd0);
    write_reg(gfta_pkg::RegTeidLimit, 32'd1);
    write_reg(gfta_pkg::RegPeerIp, 32'h0);
    write_reg(gfta_pkg::RegLocalIp, 32'hffffffff);
    cfg_if.valid <= 0;
    for (int i = 0; i < 20; i++) send_frame(good_frame(32'(i * 7)), 1'b0, z);
    in_if.valid <= 0;
    drain();

    // zero limit, small limit, full limit, then random phases
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_reg(gfta_pkg::RegTeidLimit, 32'd0);
        1: write_reg(gfta_pkg::RegTeidLimit, 32'd5);
        2: write_reg(gfta_pkg::RegTeidLimit, 32'd65535);
        default: write_reg(gfta_pkg::RegTeidLimit, 32'($urandom_range(1, 40)));
      endcase
      write_reg(gfta_pkg::RegMatchPort, ph == 2 ? 32'd65535 : 32'($urandom));
      write_reg(gfta_pkg::RegPeerIp, ph == 2 ? 32'hffffffff : $urandom);
      write_reg(gfta_pkg::RegLocalIp, ph == 2 ? 32'h0 : $urandom);
      cfg_if.valid <= 0;
      pool.delete();
      for (int i = 0; i < 24; i++) pool.push_back($urandom);
      if (ph == 3) hold_go <= 1'b1;
      for (int n = 0; n < NumRandom / 5; n++) begin
        if (ph == 4 && n == NumRandom / 10) no_idle = 1;
        k = $urandom_range(0, 9);
        if (k < 7) send_frame(good_frame(pool[$urandom_range(0, 23)]), 1'b0, z);
        else send_frame(noise_frame(), 1'b0, z);
      end
      in_if.valid <= 0;
      drain();
    end

    $display("covered %0d result words, %0d tunnelled, %0d evictions,", words_seen,
             encap_seen, evict_seen);
    $display("with register settings at their extremes and long output back-pressure");
    if (errors == 0 && expected_desc_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: sim.f
design/gfta_pkg.sv
design/gfta_if.sv
design/gfta_ram.sv
design/gtpu_flow_tunnel_assigner.sv
test/tb_gtpu_flow_tunnel_assigner.sv
